### hw/rtl/es2dt_pkg.sv
// Shared types, constants and calendar helpers for the epoch-seconds to
// date/time converter. No dependencies.
package es2dt_pkg;

  // Width of the offset-adjusted seconds total and of the divider remainder.
  localparam int unsigned TotalW = 33;
  // Width of the whole-day count.
  localparam int unsigned DaysW  = 17;

  localparam logic [16:0] SecPerDay  = 17'd86400;
  localparam logic [16:0] SecPerHour = 17'd3600;
  localparam logic [16:0] SecPerMin  = 17'd60;

  // Reciprocals for the divisions: 86400 = 128 * 675, 3600 = 16 * 225 and
  // 60 = 4 * 15. Each quotient is ((x >> 7, 4, 2) * recip) >> (36, 21, 14),
  // exact over the whole range of x.
  localparam logic [26:0] DayRecip  = 27'd101806633;  // ceil(2^36 / 675)
  localparam logic [13:0] HourRecip = 14'd9321;       // ceil(2^21 / 225)
  localparam logic [10:0] MinRecip  = 11'd1093;       // ceil(2^14 / 15)

  // 1970 taken modulo 100 and modulo 400.
  localparam logic [6:0] BaseYearMod100 = 7'd70;
  localparam logic [8:0] BaseYearMod400 = 9'd370;

  localparam logic [15:0] ZoneOffsetReset = 16'd28800;

  localparam logic [3:0] MonthFeb = 4'd1;
  localparam logic [3:0] MonthDec = 4'd11;

  typedef enum logic [1:0] {
    DIV_SEL_DAY  = 2'd0,
    DIV_SEL_HOUR = 2'd1,
    DIV_SEL_MIN  = 2'd2
  } div_sel_e;

  // Commands from the controller to the datapath.
  // div_last marks the remainder step of the selected division.
  typedef struct packed {
    logic       load;
    logic       div_step;
    div_sel_e   div_sel;
    logic       div_last;
    logic       year_step;
    logic       month_step;
    logic       out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic year_done;
    logic month_done;
    logic out_free;
  } sts_t;

  // Days in a month, zero-based month index.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    unique case (month)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      MonthFeb:                                  len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### hw/rtl/es2dt_ctrl.sv
// Sequencing controller for the epoch-seconds converter.
// Drives the datapath through es2dt_pkg command/status structs.
module es2dt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  es2dt_pkg::sts_t   sts_i,
  output es2dt_pkg::cmd_t   cmd_o
);

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DIV_DAY  = 7'b0000010,
    ST_DIV_HOUR = 7'b0000100,
    ST_DIV_MIN  = 7'b0001000,
    ST_YEAR     = 7'b0010000,
    ST_MONTH    = 7'b0100000,
    ST_DONE     = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   rem_phase_q, rem_phase_d;

  // Next state and command decode
  always_comb begin
    state_d        = state_q;
    rem_phase_d    = rem_phase_q;
    cmd_o          = '0;
    cmd_o.div_sel  = es2dt_pkg::DIV_SEL_DAY;
    in_stall_o     = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load  = 1'b1;
          rem_phase_d = 1'b0;
          state_d     = ST_DIV_DAY;
        end
      end
      ST_DIV_DAY: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_sel  = es2dt_pkg::DIV_SEL_DAY;
        if (rem_phase_q) begin
          cmd_o.div_last = 1'b1;
          rem_phase_d    = 1'b0;
          state_d        = ST_DIV_HOUR;
        end else begin
          rem_phase_d = 1'b1;
        end
      end
      ST_DIV_HOUR: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_sel  = es2dt_pkg::DIV_SEL_HOUR;
        if (rem_phase_q) begin
          cmd_o.div_last = 1'b1;
          rem_phase_d    = 1'b0;
          state_d        = ST_DIV_MIN;
        end else begin
          rem_phase_d = 1'b1;
        end
      end
      ST_DIV_MIN: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_sel  = es2dt_pkg::DIV_SEL_MIN;
        if (rem_phase_q) begin
          cmd_o.div_last = 1'b1;
          rem_phase_d    = 1'b0;
          state_d        = ST_YEAR;
        end else begin
          rem_phase_d = 1'b1;
        end
      end
      ST_YEAR: begin
        if (sts_i.year_done) begin
          state_d = ST_MONTH;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      ST_MONTH: begin
        if (sts_i.month_done) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and division phase registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rem_phase_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_phase_q <= rem_phase_d;
    end
  end

  // A new item always starts the day division with its quotient step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_DIV_DAY) && !rem_phase_q)
    else $error("day division did not start with its quotient step");

  // The hour division takes its quotient step and then its remainder step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DIV_HOUR) && !rem_phase_q) |=>
      (state_q == ST_DIV_HOUR) && rem_phase_q)
    else $error("hour division skipped its remainder step");

  // After a result is handed to the output register the controller is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (state_q == ST_IDLE) && !in_stall_o)
    else $error("controller not idle after result load");

endmodule

### hw/rtl/es2dt_dpath.sv
// Datapath for the epoch-seconds converter: reciprocal-multiply divider,
// year/month walk registers, offset register and output register. Uses es2dt_pkg.
module es2dt_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  es2dt_pkg::cmd_t   cmd_i,
  output es2dt_pkg::sts_t   sts_o,
  input  logic [31:0]       epoch_seconds_i,
  input  logic              cfg_valid_i,
  input  logic [15:0]       cfg_zone_offset_seconds_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        month_number_o,
  output logic [4:0]        day_of_month_o,
  output logic [4:0]        hour_of_day_o,
  output logic [5:0]        minute_of_hour_o
);

  localparam int unsigned TotalW = es2dt_pkg::TotalW;
  localparam int unsigned DaysW  = es2dt_pkg::DaysW;

  logic [15:0]       offset_q;
  logic [TotalW-1:0] rem_q, rem_d;
  logic [DaysW-1:0]  days_q, days_d;
  logic [4:0]        hour_q, hour_d;
  logic [5:0]        minute_q, minute_d;
  logic [6:0]        ymod100_q, ymod100_d;
  logic [8:0]        ymod400_q, ymod400_d;
  logic [3:0]        month_q, month_d;
  logic              out_valid_q, out_valid_d;
  logic [3:0]        o_month_q;
  logic [4:0]        o_day_q;
  logic [4:0]        o_hour_q;
  logic [5:0]        o_minute_q;

  logic [52:0]       day_prod;
  logic [26:0]       hour_prod;
  logic [20:0]       min_prod;
  logic [33:0]       day_back;
  logic [21:0]       hour_back;
  logic [22:0]       min_back;
  logic [TotalW-1:0] div_back;
  logic              leap;
  logic [8:0]        year_len;
  logic [4:0]        mon_len;

  // Quotients by reciprocal multiplication on the prescaled remainder
  assign day_prod  = 53'(rem_q[TotalW-1:7]) * 53'(es2dt_pkg::DayRecip);
  assign hour_prod = 27'(rem_q[16:4]) * 27'(es2dt_pkg::HourRecip);
  assign min_prod  = 21'(rem_q[11:2]) * 21'(es2dt_pkg::MinRecip);

  // Quotient times divisor, taken off the remainder in the following step
  assign day_back  = 34'(days_q) * 34'(es2dt_pkg::SecPerDay);
  assign hour_back = 22'(hour_q) * 22'(es2dt_pkg::SecPerHour);
  assign min_back  = 23'(minute_q) * 23'(es2dt_pkg::SecPerMin);

  always_comb begin
    unique case (cmd_i.div_sel)
      es2dt_pkg::DIV_SEL_DAY:  div_back = TotalW'(day_back);
      es2dt_pkg::DIV_SEL_HOUR: div_back = TotalW'(hour_back);
      es2dt_pkg::DIV_SEL_MIN:  div_back = TotalW'(min_back);
      default:                 div_back = TotalW'(min_back);
    endcase
  end

  // Gregorian leap rule from the running year residues
  assign leap     = ((ymod400_q[1:0] == 2'd0) && (ymod100_q != 7'd0)) || (ymod400_q == 9'd0);
  assign year_len = leap ? 9'd366 : 9'd365;
  assign mon_len  = es2dt_pkg::month_len(month_q, leap);

  assign sts_o.year_done  = days_q < DaysW'(year_len);
  assign sts_o.month_done = (month_q == es2dt_pkg::MonthDec) || (days_q < DaysW'(mon_len));
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  // Datapath next values
  always_comb begin
    rem_d     = rem_q;
    days_d    = days_q;
    hour_d    = hour_q;
    minute_d  = minute_q;
    ymod100_d = ymod100_q;
    ymod400_d = ymod400_q;
    month_d   = month_q;
    if (cmd_i.load) begin
      rem_d     = {1'b0, epoch_seconds_i} + TotalW'(offset_q);
      ymod100_d = es2dt_pkg::BaseYearMod100;
      ymod400_d = es2dt_pkg::BaseYearMod400;
      month_d   = 4'd0;
    end
    // Quotient step, then remainder step of the selected division
    if (cmd_i.div_step) begin
      if (cmd_i.div_last) begin
        rem_d = rem_q - div_back;
      end else begin
        unique case (cmd_i.div_sel)
          es2dt_pkg::DIV_SEL_DAY:  days_d   = day_prod[52:36];
          es2dt_pkg::DIV_SEL_HOUR: hour_d   = hour_prod[25:21];
          es2dt_pkg::DIV_SEL_MIN:  minute_d = min_prod[19:14];
          default:                 minute_d = min_prod[19:14];
        endcase
      end
    end
    // Consume one whole year
    if (cmd_i.year_step) begin
      days_d    = days_q - DaysW'(year_len);
      ymod100_d = (ymod100_q == 7'd99)  ? 7'd0 : ymod100_q + 7'd1;
      ymod400_d = (ymod400_q == 9'd399) ? 9'd0 : ymod400_q + 9'd1;
    end
    // Consume one whole month
    if (cmd_i.month_step) begin
      days_d  = days_q - DaysW'(mon_len);
      month_d = month_q + 4'd1;
    end
  end

  // Output valid: set on load, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= es2dt_pkg::ZoneOffsetReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        offset_q <= cfg_zone_offset_seconds_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    rem_q     <= rem_d;
    days_q    <= days_d;
    hour_q    <= hour_d;
    minute_q  <= minute_d;
    ymod100_q <= ymod100_d;
    ymod400_q <= ymod400_d;
    month_q   <= month_d;
  end

  // Output register, loaded only when free
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      o_month_q  <= month_q + 4'd1;
      o_day_q    <= days_q[4:0] + 5'd1;
      o_hour_q   <= hour_q;
      o_minute_q <= minute_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign month_number_o   = o_month_q;
  assign day_of_month_o   = o_day_q;
  assign hour_of_day_o    = o_hour_q;
  assign minute_of_hour_o = o_minute_q;

  // A finished walk leaves less than a month of days
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (days_q < 17'd31) && (month_q <= es2dt_pkg::MonthDec))
    else $error("month walk left too many days");

  // The minute division always ends below one minute of seconds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.div_last && (cmd_i.div_sel == es2dt_pkg::DIV_SEL_MIN)) |=>
      (rem_q < TotalW'(es2dt_pkg::SecPerMin)) && (minute_q < 6'd60))
    else $error("minute division remainder out of range");

  // Never overwrite a result that is still held by a stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && out_stall_i))
    else $error("output register overwritten while stalled");

endmodule

### hw/rtl/epoch_seconds_to_date_time.sv
// Each accepted item runs three reciprocal divisions (day, hour, minute), each
//   a quotient step and then a remainder step, then a year walk (0..136 years)
//   and a month walk (0..11 months), one year or month per cycle; in_stall_o
//   stays high until the result is loaded into the output register.
// Reset (rst_ni low, async): idle, no result pending, zone offset 28800 s.
// Top level: joins es2dt_ctrl and es2dt_dpath; types come from es2dt_pkg.
module epoch_seconds_to_date_time (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] epoch_seconds_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_zone_offset_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  month_number_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_of_day_o,
  output logic [5:0]  minute_of_hour_o
);

  es2dt_pkg::cmd_t cmd;
  es2dt_pkg::sts_t sts;

  // Offset writes are taken at any time
  assign cfg_ready_o = 1'b1;

  es2dt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  es2dt_dpath u_dpath (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .cmd_i                     (cmd),
    .sts_o                     (sts),
    .epoch_seconds_i           (epoch_seconds_i),
    .cfg_valid_i               (cfg_valid_i),
    .cfg_zone_offset_seconds_i (cfg_zone_offset_seconds_i),
    .out_valid_o               (out_valid_o),
    .out_stall_i               (out_stall_i),
    .month_number_o            (month_number_o),
    .day_of_month_o            (day_of_month_o),
    .hour_of_day_o             (hour_of_day_o),
    .minute_of_hour_o          (minute_of_hour_o)
  );

endmodule

### verif/tb.sv
// Self-checking bench for epoch_seconds_to_date_time: timestamps go in, calendar
// month/day/hour/minute come out and are checked against an in-bench calendar walk.
// Depends on es2dt_pkg and the epoch_seconds_to_date_time RTL only.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned SecondsPerDay  = 86400;
  localparam int unsigned SecondsPerHour = 3600;
  localparam int unsigned SecondsPerMin  = 60;
  localparam int unsigned EpochYear      = 1970;
  localparam int unsigned MaxGap         = 19;
  localparam int unsigned DrainCycles    = 200;
  localparam int unsigned IdleLimit      = 4000;
  localparam int unsigned PhaseItems     = 100;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
  } date_time_t;

  typedef struct {
    logic [31:0] epoch;
    int unsigned gap;
  } timestamp_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] epoch_seconds_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_zone_offset_seconds_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  month_number_o;
  logic [4:0]  day_of_month_o;
  logic [4:0]  hour_of_day_o;
  logic [5:0]  minute_of_hour_o;

  epoch_seconds_to_date_time dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .in_valid_i               (in_valid_i),
    .in_stall_o               (in_stall_o),
    .epoch_seconds_i          (epoch_seconds_i),
    .cfg_valid_i              (cfg_valid_i),
    .cfg_ready_o              (cfg_ready_o),
    .cfg_zone_offset_seconds_i(cfg_zone_offset_seconds_i),
    .out_valid_o              (out_valid_o),
    .out_stall_i              (out_stall_i),
    .month_number_o           (month_number_o),
    .day_of_month_o           (day_of_month_o),
    .hour_of_day_o            (hour_of_day_o),
    .minute_of_hour_o         (minute_of_hour_o)
  );

  // Bench copy of the offset register and bookkeeping
  logic [15:0]     zone_offset = es2dt_pkg::ZoneOffsetReset;
  timestamp_item_t pending_stamps[$];
  date_time_t      expected_dates[$];
  timestamp_item_t staged_stamp;
  logic            stamp_staged = 1'b0;
  int unsigned     send_wait = 0;
  int unsigned     recv_wait = 0;
  bit              send_idling = 1'b1;
  bit              recv_idling = 1'b1;
  int unsigned     error_count = 0;
  int unsigned     stamps_sent = 0;
  int unsigned     dates_checked = 0;
  int unsigned     offsets_written = 0;
  int unsigned     quiet_cycles = 0;

  int unsigned month_days [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit leap_year(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  // Convert seconds plus zone shift to month, day, hour and minute
  function automatic date_time_t calendar_from_epoch(input logic [31:0] secs,
                                                     input logic [15:0] zone);
    longint unsigned total;
    longint unsigned days;
    int unsigned     day_secs;
    int unsigned     yr;
    int unsigned     mon;
    int unsigned     span;
    date_time_t      d;
    total    = longint'(secs) + longint'(zone);
    days     = total / SecondsPerDay;
    day_secs = int'(total % SecondsPerDay);
    yr       = EpochYear;
    span     = leap_year(yr) ? 366 : 365;
    // Consume whole years, then whole months up to December
    while (days >= span) begin
      days -= span;
      yr++;
      span = leap_year(yr) ? 366 : 365;
    end
    mon  = 0;
    span = month_days[0];
    while (mon < 11 && days >= span) begin
      days -= span;
      mon++;
      span = (mon == 1 && leap_year(yr)) ? 29 : month_days[mon];
    end
    d.month  = 4'(mon + 1);
    d.day    = 5'(days + 1);
    d.hour   = 5'(day_secs / SecondsPerHour);
    d.minute = 6'((day_secs % SecondsPerHour) / SecondsPerMin);
    return d;
  endfunction

  function automatic int unsigned draw_gap(input bit enabled);
    return enabled ? $urandom_range(0, MaxGap) : 0;
  endfunction

  // Mix of full-range, day-aligned, near-top and near-epoch timestamps
  function automatic logic [31:0] random_epoch();
    logic [31:0] e;
    case ($urandom_range(0, 3))
      0:       e = $urandom();
      1:       e = $urandom_range(0, 49709) * SecondsPerDay
                   + ($urandom_range(0, 1) ? $urandom_range(0, 59)
                                           : $urandom_range(86340, 86399));
      2:       e = 32'hFFFF_FFFF - $urandom_range(0, 1 << 22);
      default: e = $urandom_range(0, 1 << 24);
    endcase
    return e;
  endfunction

  task automatic queue_stamp(input logic [31:0] e);
    timestamp_item_t it;
    it.epoch = e;
    it.gap   = draw_gap(send_idling);
    pending_stamps.push_back(it);
  endtask

  // Hold until every queued item is sent and every expected date has come back
  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (pending_stamps.size() != 0 || stamp_staged || in_valid_i ||
           expected_dates.size() != 0);
  endtask

  task automatic write_zone_offset(input logic [15:0] value);
    @(posedge clk_i);
    cfg_valid_i               <= 1'b1;
    cfg_zone_offset_seconds_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    zone_offset = value;
    offsets_written++;
    @(negedge clk_i);
  endtask

  task automatic directed_stamps();
    queue_stamp(32'd0);
    queue_stamp(32'hFFFF_FFFF);
    queue_stamp(32'd68169599);    // 1972-02-28 23:59:59, leap year by four
    queue_stamp(32'd68169600);    // 1972-02-29
    queue_stamp(32'd946684799);   // last second of 1999
    queue_stamp(32'd951782400);   // 2000-02-29, leap year by four hundred
    queue_stamp(32'd4107542399);  // 2100-02-28 23:59:59, century not leap
    queue_stamp(32'd4107542400);  // 2100-03-01
    wait_for_drain();
  endtask

  task automatic random_phase(input logic [15:0] offset, input bit snd, input bit rcv);
    send_idling = snd;
    recv_idling = rcv;
    write_zone_offset(offset);
    repeat (PhaseItems / 2) queue_stamp(random_epoch());
    // Let the block run dry mid-phase before the second half
    wait_for_drain();
    repeat (PhaseItems / 2) queue_stamp(random_epoch());
    wait_for_drain();
  endtask

  // Stimulus sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    directed_stamps();
    write_zone_offset(16'd0);
    directed_stamps();
    write_zone_offset(16'hFFFF);
    directed_stamps();
    random_phase(16'd50400, 1'b0, 1'b0);
    random_phase(16'($urandom_range(0, 50400)), 1'b1, 1'b0);
    random_phase(16'd0, 1'b0, 1'b1);
    random_phase(16'($urandom_range(0, 65535)), 1'b1, 1'b1);
    random_phase(es2dt_pkg::ZoneOffsetReset, 1'b1, 1'b1);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Sent %0d timestamps across %0d zone offset writes (0, 50400, 65535, random).",
             stamps_sent, offsets_written);
    $display("Checked %0d calendar results, %0d mismatches.", dates_checked, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Driver: present queued timestamps after their gap, hold while stalled
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_dates.push_back(calendar_from_epoch(epoch_seconds_i, zone_offset));
        stamps_sent++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (!stamp_staged && pending_stamps.size() != 0) begin
          staged_stamp = pending_stamps.pop_front();
          stamp_staged = 1'b1;
          send_wait    = staged_stamp.gap;
        end
        if (stamp_staged && send_wait == 0) begin
          in_valid_i      <= 1'b1;
          epoch_seconds_i <= staged_stamp.epoch;
          stamp_staged = 1'b0;
        end else begin
          in_valid_i <= 1'b0;
          if (stamp_staged) send_wait--;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [5:0] want,
                             input logic [5:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Monitor: check each accepted date, then draw the next stall stretch
  always @(posedge clk_i) begin
    date_time_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        dates_checked++;
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d/%0d %0d:%0d",
                   $time, month_number_o, day_of_month_o, hour_of_day_o,
                   minute_of_hour_o);
          error_count++;
        end else begin
          want = expected_dates.pop_front();
          check_field("month", 6'(want.month), 6'(month_number_o));
          check_field("day", 6'(want.day), 6'(day_of_month_o));
          check_field("hour", 6'(want.hour), 6'(hour_of_day_o));
          check_field("minute", want.minute, minute_of_hour_o);
        end
        recv_wait = draw_gap(recv_idling);
      end
      if (recv_wait > 0) begin
        out_stall_i <= 1'b1;
        recv_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if no handshake completes for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d dates outstanding", $time,
               quiet_cycles, expected_dates.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
